### hdl/sclb_pkg.sv
// ----------------------------------------------------------------------------
// sclb_pkg
// Shared types, codes and key tables for the scancode line buffer.
// ----------------------------------------------------------------------------
package sclb_pkg;

   localparam int FIFO_DEPTH_DEFAULT = 512;

   localparam logic [1:0] KIND_ECHO    = 2'd0;
   localparam logic [1:0] KIND_DELIVER = 2'd1;
   localparam logic [1:0] KIND_REFUSE  = 2'd2;

   localparam logic       OP_KEY  = 1'b0;
   localparam logic       OP_READ = 1'b1;

   localparam logic [7:0] SC_BREAK_BIT     = 8'h80;
   localparam logic [7:0] SC_LSHIFT_MAKE   = 8'h2A;
   localparam logic [7:0] SC_RSHIFT_MAKE   = 8'h36;
   localparam logic [7:0] SC_LSHIFT_BREAK  = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_BREAK  = 8'hB6;
   localparam logic [7:0] CH_BACKSPACE     = 8'h08;
   localparam logic [7:0] NO_READER        = 8'h00;

   typedef struct packed {
      logic       operation;
      logic [7:0] scancode;
      logic [7:0] requester;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_out;
      logic [7:0] target;
      logic       last;
   } rsp_type;

   // classified transaction handed from front to back
   typedef struct packed {
      logic       is_read;
      logic [7:0] data;     // character for a key, reader id for a read
   } cmd_type;

   function automatic logic [7:0] plain_char(input logic [6:0] code);
      logic [7:0] ch;
      case (code)
         7'd2:  ch = 8'h31;
         7'd3:  ch = 8'h32;
         7'd4:  ch = 8'h33;
         7'd5:  ch = 8'h34;
         7'd6:  ch = 8'h35;
         7'd7:  ch = 8'h36;
         7'd8:  ch = 8'h37;
         7'd9:  ch = 8'h38;
         7'd10: ch = 8'h39;
         7'd12: ch = 8'h2D;
         7'd13: ch = 8'h3D;
         7'd14: ch = 8'h08;
         7'd15: ch = 8'h09;
         7'd16: ch = 8'h71;
         7'd17: ch = 8'h77;
         7'd18: ch = 8'h65;
         7'd19: ch = 8'h72;
         7'd20: ch = 8'h74;
         7'd21: ch = 8'h7A;
         7'd22: ch = 8'h75;
         7'd23: ch = 8'h69;
         7'd24: ch = 8'h6F;
         7'd25: ch = 8'h70;
         7'd26: ch = 8'h5B;
         7'd27: ch = 8'h5D;
         7'd28: ch = 8'h0A;
         7'd30: ch = 8'h61;
         7'd31: ch = 8'h73;
         7'd32: ch = 8'h64;
         7'd33: ch = 8'h66;
         7'd34: ch = 8'h67;
         7'd35: ch = 8'h68;
         7'd36: ch = 8'h6A;
         7'd37: ch = 8'h6B;
         7'd38: ch = 8'h6C;
         7'd39: ch = 8'h3B;
         7'd40: ch = 8'h27;
         7'd41: ch = 8'h60;
         7'd43: ch = 8'h5C;
         7'd44: ch = 8'h79;
         7'd45: ch = 8'h78;
         7'd46: ch = 8'h63;
         7'd47: ch = 8'h76;
         7'd48: ch = 8'h62;
         7'd49: ch = 8'h6E;
         7'd50: ch = 8'h6D;
         7'd51: ch = 8'h2C;
         7'd52: ch = 8'h2E;
         7'd53: ch = 8'h2D;
         7'd55: ch = 8'h2A;
         7'd57: ch = 8'h20;
         7'd74: ch = 8'h2D;
         7'd78: ch = 8'h2B;
         default: ch = (code < 7'd90) ? 8'h30 : 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] shift_char(input logic [6:0] code);
      logic [7:0] ch;
      case (code)
         7'd2:  ch = 8'h21;
         7'd3:  ch = 8'h22;
         7'd5:  ch = 8'h24;
         7'd6:  ch = 8'h25;
         7'd7:  ch = 8'h26;
         7'd8:  ch = 8'h2F;
         7'd9:  ch = 8'h28;
         7'd10: ch = 8'h29;
         7'd11: ch = 8'h3D;
         7'd12: ch = 8'h3F;
         7'd13: ch = 8'h3D;
         7'd14: ch = 8'h08;
         7'd15: ch = 8'h09;
         7'd16: ch = 8'h51;
         7'd17: ch = 8'h57;
         7'd18: ch = 8'h45;
         7'd19: ch = 8'h52;
         7'd20: ch = 8'h54;
         7'd21: ch = 8'h5A;
         7'd22: ch = 8'h55;
         7'd23: ch = 8'h49;
         7'd24: ch = 8'h4F;
         7'd25: ch = 8'h50;
         7'd26: ch = 8'h5B;
         7'd27: ch = 8'h5D;
         7'd28: ch = 8'h0A;
         7'd30: ch = 8'h41;
         7'd31: ch = 8'h53;
         7'd32: ch = 8'h44;
         7'd33: ch = 8'h46;
         7'd34: ch = 8'h47;
         7'd35: ch = 8'h48;
         7'd36: ch = 8'h4A;
         7'd37: ch = 8'h4B;
         7'd38: ch = 8'h4C;
         7'd39: ch = 8'h3B;
         7'd40: ch = 8'h27;
         7'd41: ch = 8'h60;
         7'd43: ch = 8'h5C;
         7'd44: ch = 8'h59;
         7'd45: ch = 8'h58;
         7'd46: ch = 8'h43;
         7'd47: ch = 8'h56;
         7'd48: ch = 8'h42;
         7'd49: ch = 8'h4E;
         7'd50: ch = 8'h4D;
         7'd51: ch = 8'h3B;
         7'd52: ch = 8'h3A;
         7'd53: ch = 8'h5F;
         7'd55: ch = 8'h2A;
         7'd57: ch = 8'h20;
         7'd74: ch = 8'h2D;
         7'd78: ch = 8'h2B;
         default: ch = (code < 7'd90) ? 8'h30 : 8'h00;
      endcase
      return ch;
   endfunction

endpackage

### hdl/sclb_front.sv
// ----------------------------------------------------------------------------
// sclb_front
// Accepts transactions, tracks shift, translates make codes into commands.
// ----------------------------------------------------------------------------
module sclb_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  sclb_pkg::req_type req,
   output logic              req_stall,
   input  logic              cmd_full,
   output logic              cmd_push,
   output sclb_pkg::cmd_type cmd_data
);

   logic shift_ff;
   logic shift_in;
   logic accept;
   logic [7:0] code;
   logic [7:0] ch;

   assign req_stall = cmd_full;
   assign accept    = req_valid && !cmd_full;
   assign code      = req.scancode;
   assign ch        = shift_ff ? sclb_pkg::shift_char(code[6:0])
                               : sclb_pkg::plain_char(code[6:0]);

   always_comb begin
      shift_in      = shift_ff;
      cmd_push      = 1'b0;
      cmd_data      = '0;
      if (accept) begin
         if (req.operation == sclb_pkg::OP_READ) begin
            cmd_push         = 1'b1;
            cmd_data.is_read = 1'b1;
            cmd_data.data    = req.requester;
         end else if ((code & sclb_pkg::SC_BREAK_BIT) != 8'h00) begin
            if (code == sclb_pkg::SC_LSHIFT_BREAK || code == sclb_pkg::SC_RSHIFT_BREAK) begin
               shift_in = 1'b0;
            end
         end else if (code == sclb_pkg::SC_LSHIFT_MAKE || code == sclb_pkg::SC_RSHIFT_MAKE) begin
            shift_in = 1'b1;
         end else begin
            cmd_push         = 1'b1;
            cmd_data.is_read = 1'b0;
            cmd_data.data    = ch;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
      end else begin
         shift_ff <= shift_in;
      end
   end

endmodule

### hdl/sclb_cmd_queue.sv
// ----------------------------------------------------------------------------
// sclb_cmd_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module sclb_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sclb_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output sclb_pkg::cmd_type pop_data
);

   sclb_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hdl/sclb_back.sv
// ----------------------------------------------------------------------------
// sclb_back
// Executes commands: character FIFO, parked reader and result register.
// ----------------------------------------------------------------------------
module sclb_back #(
   parameter int FIFO_DEPTH = sclb_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  sclb_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              rsp_valid,
   output sclb_pkg::rsp_type rsp,
   input  logic              rsp_stall
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SECOND = 2'd1;
   localparam logic [1:0] S_READ   = 2'd2;

   logic [7:0]        mem [FIFO_DEPTH];
   logic [7:0]        rd_data_ff;

   logic [1:0]        state_ff,   state_in;
   logic [PTR_W-1:0]  head_ff,    head_in;
   logic [CNT_W-1:0]  count_ff,   count_in;
   logic [7:0]        pending_ff, pending_in;
   logic [7:0]        rd_who_ff,  rd_who_in;
   sclb_pkg::rsp_type second_ff,  second_in;
   sclb_pkg::rsp_type rsp_ff,     rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              out_free;
   logic              wr_en;
   logic              rd_en;
   logic [SUM_W-1:0]  tail_sum;
   logic [PTR_W-1:0]  tail;
   logic [PTR_W-1:0]  head_next;
   logic              is_bs;
   logic              not_full;
   logic [CNT_W-1:0]  count_key;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cmd_pop   = (state_ff == S_IDLE) && cmd_valid && out_free;

   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail      = (tail_sum >= SUM_W'(FIFO_DEPTH))
                      ? PTR_W'(tail_sum - SUM_W'(FIFO_DEPTH)) : PTR_W'(tail_sum);
   assign head_next = (head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);

   assign is_bs    = (cmd_data.data == sclb_pkg::CH_BACKSPACE);
   assign not_full = (count_ff != CNT_W'(FIFO_DEPTH));

   always_comb begin
      if (is_bs) begin
         count_key = (count_ff != '0) ? count_ff - CNT_W'(1) : count_ff;
      end else begin
         count_key = not_full ? count_ff + CNT_W'(1) : count_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      pending_in   = pending_ff;
      rd_who_in    = rd_who_ff;
      second_in    = second_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_pop) begin
               if (!cmd_data.is_read) begin
                  wr_en    = !is_bs && not_full;
                  count_in = count_key;
                  if (pending_ff != sclb_pkg::NO_READER) begin
                     pending_in = sclb_pkg::NO_READER;
                     if (!is_bs && count_key != '0) begin
                        head_in  = head_next;
                        count_in = count_key - CNT_W'(1);
                     end
                  end
                  if (count_key != '0) begin
                     rsp_valid_in    = 1'b1;
                     rsp_in.kind     = sclb_pkg::KIND_ECHO;
                     rsp_in.char_out = cmd_data.data;
                     rsp_in.target   = 8'h00;
                     rsp_in.last     = (pending_ff == sclb_pkg::NO_READER);
                     if (pending_ff != sclb_pkg::NO_READER) begin
                        second_in.kind     = sclb_pkg::KIND_DELIVER;
                        second_in.char_out = cmd_data.data;
                        second_in.target   = pending_ff;
                        second_in.last     = 1'b1;
                        state_in           = S_SECOND;
                     end
                  end else if (pending_ff != sclb_pkg::NO_READER) begin
                     rsp_valid_in    = 1'b1;
                     rsp_in.kind     = sclb_pkg::KIND_DELIVER;
                     rsp_in.char_out = cmd_data.data;
                     rsp_in.target   = pending_ff;
                     rsp_in.last     = 1'b1;
                  end
               end else if (pending_ff != sclb_pkg::NO_READER &&
                            cmd_data.data != pending_ff) begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.kind     = sclb_pkg::KIND_REFUSE;
                  rsp_in.char_out = 8'h00;
                  rsp_in.target   = cmd_data.data;
                  rsp_in.last     = 1'b1;
               end else if (count_ff == '0) begin
                  pending_in = cmd_data.data;
               end else begin
                  rd_en     = 1'b1;
                  head_in   = head_next;
                  count_in  = count_ff - CNT_W'(1);
                  rd_who_in = cmd_data.data;
                  state_in  = S_READ;
               end
            end
         end
         S_SECOND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = second_ff;
               state_in     = S_IDLE;
            end
         end
         S_READ: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.kind     = sclb_pkg::KIND_DELIVER;
               rsp_in.char_out = rd_data_ff;
               rsp_in.target   = rd_who_ff;
               rsp_in.last     = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail] <= cmd_data.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      rd_who_ff <= rd_who_in;
      second_ff <= second_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pending_ff   <= sclb_pkg::NO_READER;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/scancode_to_char_line_buffer.sv
// ----------------------------------------------------------------------------
// scancode_to_char_line_buffer
// Set-1 scancode translator with a character FIFO and one parked reader.
// ----------------------------------------------------------------------------
// Each transaction is a scancode or a read request. The front stage tracks
// shift and translates make codes in the cycle it accepts them; shift and
// unknown break codes end there. A two-entry command queue feeds the back
// stage, which owns the FIFO_DEPTH-byte character memory and the parked
// reader. A key that both echoes and delivers sends its delivery from the
// S_SECOND state; a read that pops the FIFO goes through S_READ, since the
// memory read data is registered before it goes out. A stalled result holds
// the back stage, and once the command queue is full the input stalls as
// well. Memory contents need no clearing after reset.
module scancode_to_char_line_buffer #(
   parameter int FIFO_DEPTH = sclb_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  sclb_pkg::req_type req,
   output logic              req_stall,
   output logic              rsp_valid,
   output sclb_pkg::rsp_type rsp,
   input  logic              rsp_stall
);

   logic              cmd_push;
   sclb_pkg::cmd_type cmd_push_data;
   logic              cmd_full;
   logic              cmd_pop;
   logic              cmd_valid;
   sclb_pkg::cmd_type cmd_pop_data;

   sclb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req       (req),
      .req_stall (req_stall),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_push_data)
   );

   sclb_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_valid (cmd_valid),
      .pop_data  (cmd_pop_data)
   );

   sclb_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_pop_data),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_stall (rsp_stall)
   );

endmodule

### hdl/sclb_checker.sv
// ----------------------------------------------------------------------------
// sclb_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sclb_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input sclb_pkg::rsp_type rsp,
   input logic              rsp_stall
);

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result transaction right after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled result transaction changed");

   a_echo_target : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.kind == sclb_pkg::KIND_ECHO |-> rsp.target == 8'h00)
      else $error("echo carries a reader id");

   a_deliver_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.kind == sclb_pkg::KIND_DELIVER ||
                    rsp.kind == sclb_pkg::KIND_REFUSE) |-> rsp.last)
      else $error("delivery or refusal not marked last");

   a_refuse_char : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.kind == sclb_pkg::KIND_REFUSE |->
         rsp.char_out == 8'h00)
      else $error("malformed refusal");

endmodule

bind scancode_to_char_line_buffer sclb_checker u_sclb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp       (rsp),
   .rsp_stall (rsp_stall)
);

### verif/scancode_to_char_line_buffer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scancode_to_char_line_buffer_test
// Self-checking bench for the scancode line buffer. A predictor tracks shift,
// the character FIFO and the parked reader, and works out the echo, delivery
// and refusal results of every accepted transaction. Directed keys and reads
// come first, then random typing and reads, then a key burst that fills the
// FIFO around a result-side hold-off. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

localparam logic [7:0] SC_BACKSPACE_MAKE = 8'h0E;
localparam logic [6:0] SC_TAB_CODE       = 7'd15;
localparam logic [6:0] SC_ENTER_CODE     = 7'd28;
localparam logic [6:0] SC_FIRST_UNMAPPED = 7'd90;
localparam logic [7:0] CH_TAB            = 8'h09;
localparam logic [7:0] CH_NEWLINE        = 8'h0A;
localparam int         MAX_PRINTED       = 40;

class typed_line_checker;

   string plain_keys = {"0012345678", "90-=00qwer", "tzuiop[]00", "asdfghjkl;",
                        "'`0\\yxcvbn", "m,.-0*0 00", "0000000000", "0000-000+0",
                        "0000000000"};
   string shifted_keys = {"00!\"0$%&/(", ")=?=00QWER", "TZUIOP[]00", "ASDFGHJKL;",
                          "'`0\\YXCVBN", "M;:_0*0 00", "0000000000", "0000-000+0",
                          "0000000000"};

   bit                   shift_down;
   logic [7:0]           buffered_chars[$];
   logic [7:0]           parked_reader = sclb_pkg::NO_READER;
   sclb_pkg::rsp_type    awaited_results[$];
   int                   mismatches;

   function logic [7:0] key_char(bit shifted, logic [6:0] code);
      if (code >= SC_FIRST_UNMAPPED) return 8'h00;
      if (code == SC_BACKSPACE_MAKE[6:0]) return sclb_pkg::CH_BACKSPACE;
      if (code == SC_TAB_CODE) return CH_TAB;
      if (code == SC_ENTER_CODE) return CH_NEWLINE;
      return shifted ? shifted_keys[code] : plain_keys[code];
   endfunction

   function void add_result(logic [1:0] kind, logic [7:0] ch, logic [7:0] target);
      sclb_pkg::rsp_type r;
      r.kind = kind;
      r.char_out = ch;
      r.target = target;
      r.last = 1'b0;
      awaited_results.push_back(r);
   endfunction

   function void type_key(logic [7:0] code);
      logic [7:0] ch;
      if (code & sclb_pkg::SC_BREAK_BIT) begin
         if (code == sclb_pkg::SC_LSHIFT_BREAK || code == sclb_pkg::SC_RSHIFT_BREAK)
            shift_down = 1'b0;
         return;
      end
      if (code == sclb_pkg::SC_LSHIFT_MAKE || code == sclb_pkg::SC_RSHIFT_MAKE) begin
         shift_down = 1'b1;
         return;
      end
      ch = key_char(shift_down, code[6:0]);
      if (ch == sclb_pkg::CH_BACKSPACE) begin
         if (buffered_chars.size() > 0) void'(buffered_chars.pop_back());
      end else if (buffered_chars.size() < sclb_pkg::FIFO_DEPTH_DEFAULT) begin
         buffered_chars.push_back(ch);
      end
      if (buffered_chars.size() > 0) add_result(sclb_pkg::KIND_ECHO, ch, 8'h00);
      if (parked_reader != sclb_pkg::NO_READER) begin
         add_result(sclb_pkg::KIND_DELIVER, ch, parked_reader);
         if (ch != sclb_pkg::CH_BACKSPACE && buffered_chars.size() > 0)
            void'(buffered_chars.pop_front());
         parked_reader = sclb_pkg::NO_READER;
      end
   endfunction

   function void serve_read(logic [7:0] who);
      if (parked_reader != sclb_pkg::NO_READER && who != parked_reader)
         add_result(sclb_pkg::KIND_REFUSE, 8'h00, who);
      else if (buffered_chars.size() == 0)
         parked_reader = who;
      else
         add_result(sclb_pkg::KIND_DELIVER, buffered_chars.pop_front(), who);
   endfunction

   function void note_request(sclb_pkg::req_type item);
      int queued;
      queued = awaited_results.size();
      if (item.operation == sclb_pkg::OP_READ)
         serve_read(item.requester);
      else
         type_key(item.scancode);
      if (awaited_results.size() > queued)
         awaited_results[awaited_results.size() - 1].last = 1'b1;
   endfunction

   task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("%0t ERROR %s", $time, what);
   endtask

   task check_response(sclb_pkg::rsp_type seen);
      sclb_pkg::rsp_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch($sformatf("unexpected result kind %0d char %02h target %02h",
                                   seen.kind, seen.char_out, seen.target));
         return;
      end
      want = awaited_results.pop_front();
      if (seen.kind !== want.kind)
         report_mismatch($sformatf("kind %0d, expected %0d", seen.kind, want.kind));
      if (seen.char_out !== want.char_out)
         report_mismatch($sformatf("char_out %02h, expected %02h",
                                   seen.char_out, want.char_out));
      if (seen.target !== want.target)
         report_mismatch($sformatf("target %02h, expected %02h", seen.target, want.target));
      if (seen.last !== want.last)
         report_mismatch($sformatf("last %0b, expected %0b", seen.last, want.last));
   endtask

endclass

module scancode_to_char_line_buffer_test;

   localparam int STALL_LIMIT    = 3000;
   localparam int RX_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 24;
   localparam int MIXED_ITEMS    = 430;
   localparam int BURST_ITEMS    = 560;
   localparam int TAIL_ITEMS     = 40;

   logic              clock;
   logic              reset;
   logic              req_valid;
   sclb_pkg::req_type req;
   logic              req_stall;
   logic              rsp_valid;
   sclb_pkg::rsp_type rsp;
   logic              rsp_stall;

   bit hold_off_now = 1'b0;
   int send_quiet = 0;

   typed_line_checker line_check = new();

   scancode_to_char_line_buffer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req       (req),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_stall (rsp_stall)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) line_check.note_request(req);
         if (rsp_valid && !rsp_stall) line_check.check_response(rsp);
      end
   end

   function automatic int idle_length(ref int quiet_left);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if (pick < 4) begin
         quiet_left = $urandom_range(20, 60);
         return 0;
      end
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 50);
   endfunction

   function automatic sclb_pkg::req_type make_request(logic op, logic [7:0] code,
                                                      logic [7:0] who);
      sclb_pkg::req_type item;
      item.operation = op;
      item.scancode = code;
      item.requester = who;
      return item;
   endfunction

   function automatic logic [7:0] typed_scancode();
      logic [7:0] code;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         case ($urandom_range(0, 3))
            0: code = sclb_pkg::SC_LSHIFT_MAKE;
            1: code = sclb_pkg::SC_RSHIFT_MAKE;
            2: code = sclb_pkg::SC_LSHIFT_BREAK;
            default: code = sclb_pkg::SC_RSHIFT_BREAK;
         endcase
         return code;
      end
      do begin
         code = 8'($urandom_range(2, 57));
      end while (code == sclb_pkg::SC_LSHIFT_MAKE || code == sclb_pkg::SC_RSHIFT_MAKE ||
                 code == SC_BACKSPACE_MAKE);
      return code;
   endfunction

   function automatic sclb_pkg::req_type random_request();
      sclb_pkg::req_type item;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      item.operation = sclb_pkg::OP_KEY;
      item.scancode = 8'($urandom_range(0, 255));
      item.requester = 8'($urandom_range(0, 255));
      if (pick < 32) begin
         item.operation = sclb_pkg::OP_READ;
         if (pick == 0) item.requester = sclb_pkg::NO_READER;
         else if (pick < 20) item.requester = 8'($urandom_range(1, 3));
         else item.requester = 8'($urandom_range(1, 255));
      end else if (pick < 62) begin
         item.scancode = typed_scancode();
      end else if (pick < 70) begin
         item.scancode = SC_BACKSPACE_MAKE;
      end else if (pick < 78) begin
         item.scancode = sclb_pkg::SC_BREAK_BIT | 8'($urandom_range(0, 127));
      end else if (pick < 84) begin
         item.scancode = 8'($urandom_range(SC_FIRST_UNMAPPED, 127));
      end
      return item;
   endfunction

   task automatic send_request(input sclb_pkg::req_type item);
      int gap;
      gap = idle_length(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic await_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (line_check.awaited_results.size() != 0) @(posedge clock);
   endtask

   initial begin : result_side
      int stall_len;
      int quiet_left;
      quiet_left = 0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_now) begin
            hold_off_now = 1'b0;
            stall_len = RX_HOLD_CYCLES;
         end else begin
            stall_len = idle_length(quiet_left);
         end
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      reset <= 1'b1;
      req_valid <= 1'b0;
      req <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty buffer: reader 0 dropped, stray break, backspace, park and refuse
      send_request(make_request(sclb_pkg::OP_READ, 8'h00, sclb_pkg::NO_READER));
      send_request(make_request(sclb_pkg::OP_KEY, 8'h80, 8'h00));
      send_request(make_request(sclb_pkg::OP_KEY, SC_BACKSPACE_MAKE, 8'h00));
      send_request(make_request(sclb_pkg::OP_READ, 8'h00, 8'hFF));
      send_request(make_request(sclb_pkg::OP_READ, 8'h00, 8'h01));
      send_request(make_request(sclb_pkg::OP_READ, 8'h00, 8'hFF));
      send_request(make_request(sclb_pkg::OP_KEY, 8'h10, 8'h00));
      // both shift keys, unmapped and extreme codes
      send_request(make_request(sclb_pkg::OP_KEY, sclb_pkg::SC_LSHIFT_MAKE, 8'h00));
      send_request(make_request(sclb_pkg::OP_KEY, 8'h10, 8'h00));
      send_request(make_request(sclb_pkg::OP_KEY, 8'h03, 8'h00));
      send_request(make_request(sclb_pkg::OP_KEY, sclb_pkg::SC_LSHIFT_BREAK, 8'h00));
      send_request(make_request(sclb_pkg::OP_KEY, sclb_pkg::SC_RSHIFT_MAKE, 8'h00));
      send_request(make_request(sclb_pkg::OP_KEY, 8'h35, 8'h00));
      send_request(make_request(sclb_pkg::OP_KEY, sclb_pkg::SC_RSHIFT_BREAK, 8'h00));
      send_request(make_request(sclb_pkg::OP_KEY, 8'h7F, 8'h00));
      send_request(make_request(sclb_pkg::OP_KEY, 8'h00, 8'h00));
      send_request(make_request(sclb_pkg::OP_KEY, 8'hFF, 8'h00));
      send_request(make_request(sclb_pkg::OP_READ, 8'h00, 8'h01));
      send_request(make_request(sclb_pkg::OP_KEY, SC_BACKSPACE_MAKE, 8'h00));
      send_request(make_request(sclb_pkg::OP_READ, 8'h00, 8'h80));
      send_request(make_request(sclb_pkg::OP_READ, 8'h00, sclb_pkg::NO_READER));
      send_request(make_request(sclb_pkg::OP_READ, 8'h00, 8'h7F));
      // parked reader served by a backspace, then by enter
      send_request(make_request(sclb_pkg::OP_READ, 8'h00, 8'h55));
      send_request(make_request(sclb_pkg::OP_KEY, SC_BACKSPACE_MAKE, 8'h00));
      send_request(make_request(sclb_pkg::OP_READ, 8'h00, 8'h42));
      send_request(make_request(sclb_pkg::OP_KEY, 8'h1C, 8'h00));
      await_results();

      repeat (MIXED_ITEMS) send_request(random_request());
      await_results();

      // fill the FIFO past full around a hold-off of the result side
      for (int i = 0; i < BURST_ITEMS; i++) begin
         if (i == 60) hold_off_now = 1'b1;
         send_request(make_request(sclb_pkg::OP_KEY, typed_scancode(),
                                   8'($urandom_range(0, 255))));
      end

      repeat (TAIL_ITEMS) send_request(random_request());
      await_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (line_check.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### scancode_to_char_line_buffer.f
hdl/sclb_pkg.sv
hdl/sclb_front.sv
hdl/sclb_cmd_queue.sv
hdl/sclb_back.sv
hdl/scancode_to_char_line_buffer.sv
hdl/sclb_checker.sv
verif/scancode_to_char_line_buffer_test.sv
